// ----- design/scc_pkg.sv -----
package scc_pkg;

  localparam int OP_W        = 3;
  localparam int ELAPSED_W   = 12;
  localparam int SPEED_W     = 2;
  localparam int FACTOR_W    = 10;
  localparam int DAY_W       = 8;
  localparam int MONTH_W     = 4;
  localparam int YEAR_OUT_W  = 16;
  localparam int ACC_W       = 32;
  localparam int MLEN_W      = 5;
  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  // elapsed time arrives in 1/1024 second units
  localparam int ELAPSED_FRAC = 10;

  localparam int HOURS_PER_DAY  = 24;
  localparam int HOURS_PER_WEEK = 168;
  localparam int MONTHS         = 12;

  // day = hours / 24 = (hours / 8) / 3; day saturates once hours reach 24*256,
  // so below that point hours fit in 13 bits
  localparam int SAT_BITS   = 13;
  localparam int DIV8_BITS  = 3;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_W     = 20;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [SPEED_W-1:0] speed_t;

  localparam op_t OP_TICK   = 3'd0;
  localparam op_t OP_SLOWER = 3'd1;
  localparam op_t OP_FASTER = 3'd2;
  localparam op_t OP_PAUSE  = 3'd3;
  localparam op_t OP_SET    = 3'd4;

  localparam speed_t SPEED_PAUSE  = 2'd0;
  localparam speed_t SPEED_SLOW   = 2'd1;
  localparam speed_t SPEED_NORMAL = 2'd2;
  localparam speed_t SPEED_FAST   = 2'd3;

  localparam logic [1:0] REG_SLOW   = 2'd0;
  localparam logic [1:0] REG_NORMAL = 2'd1;
  localparam logic [1:0] REG_FAST   = 2'd2;

  localparam logic [FACTOR_W-1:0] SLOW_RESET   = 10'd1;
  localparam logic [FACTOR_W-1:0] NORMAL_RESET = 10'd4;
  localparam logic [FACTOR_W-1:0] FAST_RESET   = 10'd16;

  typedef struct packed {
    logic [FACTOR_W-1:0] slow;
    logic [FACTOR_W-1:0] normal;
    logic [FACTOR_W-1:0] fast;
  } factors_t;

  typedef struct packed {
    op_t    op;
    speed_t sval;
  } stage_ctl_t;

  function automatic int inc_width(int fb);
    return ELAPSED_W + FACTOR_W + ((fb >= ELAPSED_FRAC) ? fb - ELAPSED_FRAC : 0);
  endfunction

  function automatic logic [MLEN_W-1:0] month_length(logic [MONTH_W-1:0] m);
    logic [MLEN_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- design/scc_channels.sv -----
interface scc_request_if;
  import scc_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  logic [ELAPSED_W-1:0] elapsed_time;
  speed_t speed_value;

  modport source (output valid, operation, elapsed_time, speed_value, input ready);
  modport sink   (input valid, operation, elapsed_time, speed_value, output ready);
endinterface

interface scc_result_if;
  import scc_pkg::*;

  logic   valid;
  logic   ready;
  logic [YEAR_OUT_W-1:0] year_now;
  logic [MONTH_W-1:0]    month_now;
  logic [DAY_W-1:0]      day_now;
  speed_t speed_now;
  logic   day_passed;
  logic   week_passed;
  logic   month_passed;
  logic   year_passed;
  logic   autosave_due;

  modport source (output valid, year_now, month_now, day_now, speed_now, day_passed,
                  week_passed, month_passed, year_passed, autosave_due, input ready);
  modport sink   (input valid, year_now, month_now, day_now, speed_now, day_passed,
                  week_passed, month_passed, year_passed, autosave_due, output ready);
endinterface

// ----- design/scaled_calendar_clock.sv -----
// channel   dir  handshake      payload
// request   in   valid/ready    operation, elapsed_time, speed_value
// result    out  valid/ready    year_now .. autosave_due, one per request
// apb       in   psel/penable   slow_factor, normal_factor, fast_factor at 0x0/0x4/0x8
//
// One request per cycle while the result side accepts; each accepted request is registered
// in an input stage holding the scaled increment (factor multiply), then passes the calendar
// update into the result register. Speed changes forward into the next request's multiply.
// Synchronous reset restores 24 hours, day/month/year 1 and normal speed.
// A stalled result holds its register; requests keep flowing until the input stage fills.
module scaled_calendar_clock #(
  parameter int FRACTION_BITS = 10,
  parameter int YEAR_WIDTH    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  scc_request_if.sink                 request,
  scc_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scc_pkg::APB_AW-1:0]  paddr,
  input  logic [scc_pkg::APB_DW-1:0]  pwdata,
  output logic [scc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import scc_pkg::*;

  localparam int INC_W = inc_width(FRACTION_BITS);

  factors_t         factors;
  speed_t           speed_fwd;
  logic             advance;
  logic             stg_valid;
  stage_ctl_t       stg_ctl;
  logic [INC_W-1:0] stg_inc;

  scc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .factors (factors)
  );

  scc_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .INC_W         (INC_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .factors   (factors),
    .speed_fwd (speed_fwd),
    .advance   (advance),
    .stg_valid (stg_valid),
    .stg_ctl   (stg_ctl),
    .stg_inc   (stg_inc)
  );

  scc_calendar #(
    .FRACTION_BITS (FRACTION_BITS),
    .YEAR_WIDTH    (YEAR_WIDTH),
    .INC_W         (INC_W)
  ) u_calendar (
    .clk       (clk),
    .rst       (rst),
    .stg_valid (stg_valid),
    .stg_ctl   (stg_ctl),
    .stg_inc   (stg_inc),
    .advance   (advance),
    .speed_fwd (speed_fwd),
    .result    (result)
  );

endmodule

// ----- design/scc_cfg.sv -----
module scc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scc_pkg::APB_AW-1:0]   paddr,
  input  logic [scc_pkg::APB_DW-1:0]   pwdata,
  output logic [scc_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output scc_pkg::factors_t            factors
);
  import scc_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_AW-1:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      factors.slow   <= SLOW_RESET;
      factors.normal <= NORMAL_RESET;
      factors.fast   <= FAST_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_SLOW:   factors.slow   <= pwdata[FACTOR_W-1:0];
        REG_NORMAL: factors.normal <= pwdata[FACTOR_W-1:0];
        REG_FAST:   factors.fast   <= pwdata[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_SLOW:   prdata = APB_DW'(factors.slow);
      REG_NORMAL: prdata = APB_DW'(factors.normal);
      REG_FAST:   prdata = APB_DW'(factors.fast);
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- design/scc_front.sv -----
module scc_front #(
  parameter int FRACTION_BITS = 10,
  parameter int INC_W         = scc_pkg::inc_width(FRACTION_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  scc_request_if.sink          request,
  input  scc_pkg::factors_t    factors,
  input  scc_pkg::speed_t      speed_fwd,
  input  logic                 advance,
  output logic                 stg_valid,
  output scc_pkg::stage_ctl_t  stg_ctl,
  output logic [INC_W-1:0]     stg_inc
);
  import scc_pkg::*;

  localparam int PROD_W = ELAPSED_W + FACTOR_W;
  localparam int SHL = (FRACTION_BITS >= ELAPSED_FRAC) ? FRACTION_BITS - ELAPSED_FRAC : 0;
  localparam int SHR = (FRACTION_BITS <  ELAPSED_FRAC) ? ELAPSED_FRAC - FRACTION_BITS : 0;

  logic [FACTOR_W-1:0] factor;
  logic [PROD_W-1:0]   prod;
  logic [INC_W-1:0]    inc_new;
  logic                take;

  assign request.ready = !stg_valid || advance;
  assign take          = request.valid && request.ready;

  always_comb begin
    unique case (speed_fwd)
      SPEED_SLOW:   factor = factors.slow;
      SPEED_NORMAL: factor = factors.normal;
      SPEED_FAST:   factor = factors.fast;
      default:      factor = '0;
    endcase
  end

  assign prod    = PROD_W'(request.elapsed_time) * PROD_W'(factor);
  assign inc_new = (INC_W'(prod) << SHL) >> SHR;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (request.ready) begin
      stg_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_ctl.op   <= request.operation;
      stg_ctl.sval <= request.speed_value;
      stg_inc      <= inc_new;
    end
  end

endmodule

// ----- design/scc_calendar.sv -----
module scc_calendar #(
  parameter int FRACTION_BITS = 10,
  parameter int YEAR_WIDTH    = 16,
  parameter int INC_W         = scc_pkg::inc_width(FRACTION_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 stg_valid,
  input  scc_pkg::stage_ctl_t  stg_ctl,
  input  logic [INC_W-1:0]     stg_inc,
  output logic                 advance,
  output scc_pkg::speed_t      speed_fwd,
  scc_result_if.source         result
);
  import scc_pkg::*;

  localparam int HOURS_W = ACC_W - FRACTION_BITS;
  localparam logic [ACC_W-1:0] HOUR_INIT  = ACC_W'(HOURS_PER_DAY) << FRACTION_BITS;
  localparam logic [ACC_W-1:0] WEEK_LIMIT = ACC_W'(HOURS_PER_WEEK) << FRACTION_BITS;
  localparam logic [HOURS_W-1:0] DAY_SAT_HOURS = HOURS_W'(HOURS_PER_DAY) << DAY_W;

  logic [ACC_W-1:0]      hour_acc, hour_acc_next;
  logic [ACC_W-1:0]      week_acc, week_acc_next;
  logic [DAY_W-1:0]      day_reg, day_reg_next;
  logic [MONTH_W-1:0]    month, month_next;
  logic [YEAR_WIDTH-1:0] year, year_next;
  speed_t                speed, speed_next;

  logic                  fire;
  logic                  tick;
  logic [ACC_W:0]        hour_sum, week_sum;
  logic [ACC_W-1:0]      hour_sat, week_sat;
  logic [HOURS_W-1:0]    hours;
  logic [DIV3_W-1:0]     div3_prod;
  logic [DAY_W-1:0]      day_calc;
  logic [MLEN_W-1:0]     month_len;
  logic                  dpass, wpass, mpass, ypass, asave;
  logic [DAY_W-1:0]      day_out;

  assign advance   = !result.valid || result.ready;
  assign fire      = stg_valid && advance;
  assign tick      = stg_ctl.op == OP_TICK;
  assign speed_fwd = speed_next;

  assign hour_sum = {1'b0, hour_acc} + (ACC_W + 1)'(stg_inc);
  assign week_sum = {1'b0, week_acc} + (ACC_W + 1)'(stg_inc);
  assign hour_sat = hour_sum[ACC_W] ? '1 : hour_sum[ACC_W-1:0];
  assign week_sat = week_sum[ACC_W] ? '1 : week_sum[ACC_W-1:0];
  assign hours    = hour_sat[ACC_W-1:FRACTION_BITS];

  assign div3_prod = DIV3_W'(hours[SAT_BITS-1:DIV8_BITS]) * DIV3_W'(DIV3_MUL);
  assign day_calc  = (hours >= DAY_SAT_HOURS) ? '1
                   : div3_prod[DIV3_SHIFT+DAY_W-1:DIV3_SHIFT];
  assign month_len = month_length(month);

  always_comb begin
    speed_next = speed;
    if (fire) begin
      case (stg_ctl.op)
        OP_SLOWER: if (speed != SPEED_PAUSE) speed_next = speed - 1'b1;
        OP_FASTER: if (speed != SPEED_FAST)  speed_next = speed + 1'b1;
        OP_PAUSE:  speed_next = SPEED_PAUSE;
        OP_SET:    speed_next = stg_ctl.sval;
        default: ;
      endcase
    end
  end

  always_comb begin
    hour_acc_next = hour_acc;
    week_acc_next = week_acc;
    day_reg_next  = day_reg;
    month_next    = month;
    year_next     = year;
    dpass         = 1'b0;
    wpass         = 1'b0;
    mpass         = 1'b0;
    ypass         = 1'b0;
    asave         = 1'b0;
    day_out       = day_reg;
    if (tick) begin
      hour_acc_next = hour_sat;
      week_acc_next = week_sat;
      day_reg_next  = day_calc;
      day_out       = day_calc;
      if (week_sat >= WEEK_LIMIT) begin
        week_acc_next = '0;
        wpass         = 1'b1;
      end
      dpass = ({1'b0, day_calc} == {1'b0, day_reg} + 1'b1) || (day_reg > day_calc);
      if (month_len != '0 && day_calc > DAY_W'(month_len)) begin
        mpass         = 1'b1;
        asave         = (month == 4'd1) || (month == 4'd7);
        hour_acc_next = HOUR_INIT;
        if (month == MONTH_W'(MONTHS)) begin
          month_next = MONTH_W'(1);
          year_next  = year + 1'b1;
          ypass      = 1'b1;
        end else begin
          month_next = month + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_acc <= HOUR_INIT;
      week_acc <= '0;
      day_reg  <= DAY_W'(1);
      month    <= MONTH_W'(1);
      year     <= YEAR_WIDTH'(1);
      speed    <= SPEED_NORMAL;
    end else if (fire) begin
      hour_acc <= hour_acc_next;
      week_acc <= week_acc_next;
      day_reg  <= day_reg_next;
      month    <= month_next;
      year     <= year_next;
      speed    <= speed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.year_now     <= YEAR_OUT_W'(year_next);
      result.month_now    <= month_next;
      result.day_now      <= day_out;
      result.speed_now    <= speed_next;
      result.day_passed   <= dpass;
      result.week_passed  <= wpass;
      result.month_passed <= mpass;
      result.year_passed  <= ypass;
      result.autosave_due <= asave;
    end
  end

endmodule

// ----- design/scc_checker.sv -----
module scc_checker (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [3:0] month_now,
  input logic       month_passed,
  input logic       year_passed,
  input logic       autosave_due
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(month_now) && $stable(month_passed))
    else $error("result changed while stalled");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> month_now >= 4'd1 && month_now <= 4'd12)
    else $error("month out of range");

  a_year_roll: assert property (@(posedge clk) disable iff (rst)
    valid && year_passed |-> month_passed && month_now == 4'd1)
    else $error("year rolled without January");

  a_autosave: assert property (@(posedge clk) disable iff (rst)
    valid && autosave_due |-> month_passed && (month_now == 4'd2 || month_now == 4'd8))
    else $error("autosave outside January or July end");

endmodule

bind scaled_calendar_clock scc_checker u_scc_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (result.valid),
  .ready        (result.ready),
  .month_now    (result.month_now),
  .month_passed (result.month_passed),
  .year_passed  (result.year_passed),
  .autosave_due (result.autosave_due)
);

// ----- tb/tb_scaled_calendar_clock.sv -----
module tb_scaled_calendar_clock;
  import scc_pkg::*;

  localparam int FRAC         = 10;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE       = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int MAX_REPORTS  = 100;

  localparam op_t OP_RESERVED_LO = 3'd5;
  localparam op_t OP_RESERVED_HI = 3'd7;

  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] JULY     = 4'd7;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  typedef struct packed {
    op_t                  op;
    logic [ELAPSED_W-1:0] elapsed;
    speed_t               sval;
  } request_t;

  typedef struct packed {
    logic [YEAR_OUT_W-1:0] year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    speed_t                speed;
    logic                  day_p;
    logic                  week_p;
    logic                  month_p;
    logic                  year_p;
    logic                  autosave;
  } calendar_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  scc_request_if request();
  scc_result_if  result();

  scaled_calendar_clock u_top (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  request_t  pending_q[$];
  calendar_t expected_q[$];
  request_t  offered;

  logic [FACTOR_W-1:0]   slow_f, normal_f, fast_f;
  logic [ACC_W-1:0]      hours_q, week_q;
  logic [DAY_W-1:0]      day_q;
  logic [MONTH_W-1:0]    month_q;
  logic [YEAR_OUT_W-1:0] year_q;
  speed_t                speed_q;

  int unsigned month_days [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  int  gap_left, stall_left, hold_left, idle_cycles;
  bit  steady, hold_req;
  int  errors, accepted_n, ticks_sent, results_n;
  int  days_seen, weeks_seen, months_seen, years_seen, saves_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  function automatic calendar_t advance_calendar(request_t r);
    calendar_t           c;
    logic [FACTOR_W-1:0] factor;
    logic [63:0]         inc, sum;
    int unsigned         day, prev;
    c = '0;
    c.day = day_q;
    case (r.op)
      OP_TICK: begin
        ticks_sent++;
        case (speed_q)
          SPEED_SLOW:   factor = slow_f;
          SPEED_NORMAL: factor = normal_f;
          SPEED_FAST:   factor = fast_f;
          default:      factor = '0;
        endcase
        inc = 64'(r.elapsed) * 64'(factor);
        sum = 64'(hours_q) + inc;
        hours_q = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
        sum = 64'(week_q) + inc;
        week_q = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
        prev = day_q;
        day = (hours_q >> FRAC) / HOURS_PER_DAY;
        if (day > 255) day = 255;
        day_q = DAY_W'(day);
        c.day = day_q;
        if (week_q >= (ACC_W'(HOURS_PER_WEEK) << FRAC)) begin
          week_q = '0;
          c.week_p = 1'b1;
        end
        c.day_p = (day == prev + 1) || (prev > day);
        if (day > month_days[month_q]) begin
          c.month_p = 1'b1;
          c.autosave = (month_q == JANUARY) || (month_q == JULY);
          hours_q = ACC_W'(HOURS_PER_DAY) << FRAC;
          if (month_q == DECEMBER) begin
            month_q = JANUARY;
            year_q++;
            c.year_p = 1'b1;
          end else begin
            month_q++;
          end
        end
      end
      OP_SLOWER: if (speed_q != SPEED_PAUSE) speed_q--;
      OP_FASTER: if (speed_q != SPEED_FAST) speed_q++;
      OP_PAUSE:  speed_q = SPEED_PAUSE;
      OP_SET:    speed_q = r.sval;
      default: ;
    endcase
    c.year  = year_q;
    c.month = month_q;
    c.speed = speed_q;
    return c;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic request_t make_request(op_t op, logic [ELAPSED_W-1:0] e, speed_t s);
    request_t r;
    r.op = op;
    r.elapsed = e;
    r.sval = s;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 62)      r.op = OP_TICK;
    else if (pick < 72) r.op = OP_SLOWER;
    else if (pick < 82) r.op = OP_FASTER;
    else if (pick < 86) r.op = OP_PAUSE;
    else if (pick < 95) r.op = OP_SET;
    else                r.op = op_t'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    pick = $urandom_range(0, 9);
    if (pick == 0)      r.elapsed = '0;
    else if (pick == 1) r.elapsed = '1;
    else                r.elapsed = ELAPSED_W'($urandom);
    r.sval = speed_t'($urandom);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      request.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (request.valid && request.ready) begin
        expected_q.push_back(advance_calendar(offered));
        accepted_n++;
      end
      if (!request.valid || request.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          request.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          offered = pending_q.pop_front();
          request.valid        <= 1'b1;
          request.operation    <= offered.op;
          request.elapsed_time <= offered.elapsed;
          request.speed_value  <= offered.sval;
          gap_left = idle_len();
        end else begin
          request.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    calendar_t want;
    if (rst) begin
      result.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (result.valid && result.ready) begin
        results_n++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (result.year_now !== want.year)
            report_mismatch("year_now", result.year_now, want.year);
          if (result.month_now !== want.month)
            report_mismatch("month_now", result.month_now, want.month);
          if (result.day_now !== want.day)
            report_mismatch("day_now", result.day_now, want.day);
          if (result.speed_now !== want.speed)
            report_mismatch("speed_now", result.speed_now, want.speed);
          if (result.day_passed !== want.day_p)
            report_mismatch("day_passed", result.day_passed, want.day_p);
          if (result.week_passed !== want.week_p)
            report_mismatch("week_passed", result.week_passed, want.week_p);
          if (result.month_passed !== want.month_p)
            report_mismatch("month_passed", result.month_passed, want.month_p);
          if (result.year_passed !== want.year_p)
            report_mismatch("year_passed", result.year_passed, want.year_p);
          if (result.autosave_due !== want.autosave)
            report_mismatch("autosave_due", result.autosave_due, want.autosave);
          days_seen   += want.day_p;
          weeks_seen  += want.week_p;
          months_seen += want.month_p;
          years_seen  += want.year_p;
          saves_seen  += want.autosave;
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (result.valid && result.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL scaled_calendar_clock");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [FACTOR_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SLOW:   slow_f = value;
      REG_NORMAL: normal_f = value;
      default:    fast_f = value;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk); while (pending_q.size() > 0 || request.valid || expected_q.size() > 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(input logic [FACTOR_W-1:0] s, input logic [FACTOR_W-1:0] n,
                           input logic [FACTOR_W-1:0] f, input int count,
                           input bit hold, input bit quiet);
    apb_write(REG_SLOW, s);
    apb_write(REG_NORMAL, n);
    apb_write(REG_FAST, f);
    @(negedge clk);
    steady = quiet;
    repeat (count) pending_q.push_back(random_request());
    if (hold) hold_req = 1'b1;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    request.valid = 1'b0;
    request.operation = OP_TICK;
    request.elapsed_time = '0;
    request.speed_value = SPEED_PAUSE;
    result.ready = 1'b0;
    steady = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    errors = 0;
    accepted_n = 0;
    ticks_sent = 0;
    results_n = 0;
    days_seen = 0;
    weeks_seen = 0;
    months_seen = 0;
    years_seen = 0;
    saves_seen = 0;
    slow_f = SLOW_RESET;
    normal_f = NORMAL_RESET;
    fast_f = FAST_RESET;
    hours_q = ACC_W'(HOURS_PER_DAY) << FRAC;
    week_q = '0;
    day_q = 8'd1;
    month_q = JANUARY;
    year_q = 16'd1;
    speed_q = SPEED_NORMAL;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset factors: extremes of elapsed time, speed limits, every operation
    @(negedge clk);
    pending_q.push_back(make_request(OP_TICK, '0, SPEED_PAUSE));
    pending_q.push_back(make_request(OP_TICK, '1, SPEED_FAST));
    pending_q.push_back(make_request(OP_TICK, '1, SPEED_PAUSE));
    pending_q.push_back(make_request(OP_SLOWER, '0, SPEED_FAST));
    pending_q.push_back(make_request(OP_SLOWER, '1, SPEED_PAUSE));
    pending_q.push_back(make_request(OP_SLOWER, '0, SPEED_NORMAL));
    pending_q.push_back(make_request(OP_TICK, '1, SPEED_FAST));
    pending_q.push_back(make_request(OP_FASTER, '0, SPEED_PAUSE));
    pending_q.push_back(make_request(OP_FASTER, '1, SPEED_SLOW));
    pending_q.push_back(make_request(OP_FASTER, '0, SPEED_PAUSE));
    pending_q.push_back(make_request(OP_FASTER, '1, SPEED_PAUSE));
    pending_q.push_back(make_request(OP_TICK, '1, SPEED_PAUSE));
    pending_q.push_back(make_request(OP_PAUSE, '1, SPEED_FAST));
    pending_q.push_back(make_request(OP_SET, '0, SPEED_SLOW));
    pending_q.push_back(make_request(OP_SET, '1, SPEED_NORMAL));
    pending_q.push_back(make_request(OP_SET, '0, SPEED_FAST));
    pending_q.push_back(make_request(OP_SET, '1, SPEED_PAUSE));
    pending_q.push_back(make_request(OP_RESERVED_LO, '1, SPEED_FAST));
    pending_q.push_back(make_request(op_t'(OP_RESERVED_LO + 1), '1, SPEED_SLOW));
    pending_q.push_back(make_request(OP_RESERVED_HI, '0, SPEED_NORMAL));
    pending_q.push_back(make_request(OP_SET, '1, SPEED_FAST));
    pending_q.push_back(make_request(OP_TICK, '0, SPEED_FAST));
    pending_q.push_back(make_request(OP_TICK, '1, SPEED_PAUSE));
    drain();

    // extreme factors roll a month on most ticks and walk through years
    run_phase('0, '1, '1, 400, 1'b0, 1'b0);
    // small factors step day by day; hold the result side to back up the pipe
    run_phase(10'd1, 10'd4, 10'd16, 500, 1'b1, 1'b0);
    run_phase('1, '0, 10'd512, 250, 1'b0, 1'b1);
    run_phase(FACTOR_W'($urandom), FACTOR_W'($urandom), FACTOR_W'($urandom), 250, 1'b0, 1'b0);
    run_phase(FACTOR_W'($urandom_range(0, 40)), FACTOR_W'($urandom_range(0, 40)),
              FACTOR_W'($urandom), 250, 1'b1, 1'b0);

    $display("covered %0d requests (%0d ticks) over six factor settings, %0d results",
             accepted_n, ticks_sent, results_n);
    $display("rollovers seen: %0d day, %0d week, %0d month, %0d year, %0d autosave",
             days_seen, weeks_seen, months_seen, years_seen, saves_seen);
    if (errors == 0)
      $display("PASS scaled_calendar_clock");
    else
      $display("FAIL scaled_calendar_clock");
    $finish;
  end

endmodule

// ----- scaled_calendar_clock.f -----
design/scc_pkg.sv
design/scc_channels.sv
design/scc_cfg.sv
design/scc_front.sv
design/scc_calendar.sv
design/scaled_calendar_clock.sv
design/scc_checker.sv
tb/tb_scaled_calendar_clock.sv
